### hw/rtl/pid_speed_loop_filtered_derivative_top_defines.svh
// assertion macros used by the checker file pidsl_chk.sv
`ifndef PID_SPEED_LOOP_FILTERED_DERIVATIVE_TOP_DEFINES_SVH
`define PID_SPEED_LOOP_FILTERED_DERIVATIVE_TOP_DEFINES_SVH

// clocked assertion, masked while reset is high
`define PIDSL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds across reset
`define PIDSL_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/pidsl_pkg.sv
// shared types and constants for the speed loop pid controller
`default_nettype none

package pidsl_pkg;

  localparam int GAIN_W      = 32;
  localparam int COEFF_W     = 17;
  localparam int MINSP_W     = 17;
  localparam int DRIVE_W     = 17;
  localparam int FILT_W      = 48;
  localparam int TERM_W      = 64;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [COEFF_W-1:0] COEFF_ONE   = 17'd65536;
  localparam logic [MINSP_W-1:0] MINSP_RESET = 17'd20;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_P_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_I_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_D_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_D_COEFF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SP  = 3'd4;

  // gain multiplier operand select
  localparam logic [1:0] MUL_P = 2'd0;
  localparam logic [1:0] MUL_I = 2'd1;
  localparam logic [1:0] MUL_D = 2'd2;

  typedef struct packed {
    logic       in_ready;
    logic       load_in;
    logic       err_ld;
    logic       idle_ld;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       take_p;
    logic       take_i;
    logic       take_d;
    logic       filt_mul;
    logic       filt_upd;
    logic       sum_ld;
    logic       out_push;
  } ctl_t;

  typedef struct packed {
    logic idle_hit;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

### hw/rtl/pidsl_ctrl.sv
// sequencer for the speed loop pid datapath
`default_nettype none

module pidsl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  pidsl_pkg::stat_t  stat,
  output pidsl_pkg::ctl_t   ctl
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_ERR  = 4'd1;
  localparam logic [3:0] ST_MP   = 4'd2;
  localparam logic [3:0] ST_MI   = 4'd3;
  localparam logic [3:0] ST_MD   = 4'd4;
  localparam logic [3:0] ST_DT   = 4'd5;
  localparam logic [3:0] ST_FM   = 4'd6;
  localparam logic [3:0] ST_FU   = 4'd7;
  localparam logic [3:0] ST_SUM  = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctl        = '0;
    ctl.mul_sel = pidsl_pkg::MUL_P;
    state_next = state;
    case (state)
      ST_IDLE: begin
        ctl.in_ready = 1'b1;
        if (in_valid) begin
          ctl.load_in = 1'b1;
          state_next  = ST_ERR;
        end
      end
      ST_ERR: begin
        ctl.err_ld = 1'b1;
        if (stat.idle_hit) begin
          ctl.idle_ld = 1'b1;
          state_next  = ST_DONE;
        end else begin
          state_next = ST_MP;
        end
      end
      ST_MP: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = pidsl_pkg::MUL_P;
        state_next  = ST_MI;
      end
      ST_MI: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = pidsl_pkg::MUL_I;
        ctl.take_p  = 1'b1;
        state_next  = ST_MD;
      end
      ST_MD: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = pidsl_pkg::MUL_D;
        ctl.take_i  = 1'b1;
        state_next  = ST_DT;
      end
      ST_DT: begin
        ctl.take_d = 1'b1;
        state_next = ST_FM;
      end
      ST_FM: begin
        ctl.filt_mul = 1'b1;
        state_next   = ST_FU;
      end
      ST_FU: begin
        ctl.filt_upd = 1'b1;
        state_next   = ST_SUM;
      end
      ST_SUM: begin
        ctl.sum_ld = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          ctl.out_push = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/pidsl_dp.sv
// datapath: config registers, loop state, shared gain multiplier, filter and output register
`default_nettype none

module pidsl_dp #(
  parameter int SPEED_BITS     = 18,
  parameter int TERM_FRAC_BITS = 24
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  pidsl_pkg::ctl_t                         ctl,
  output pidsl_pkg::stat_t                        stat,
  input  logic signed [SPEED_BITS-1:0]            setpoint,
  input  logic signed [SPEED_BITS-1:0]            measured,
  input  logic                                    cfg_we,
  input  logic [pidsl_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [pidsl_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                    out_ready,
  output logic                                    out_valid,
  output logic signed [pidsl_pkg::DRIVE_W-1:0]    drive,
  output logic                                    idle
);

  localparam int ERR_W    = SPEED_BITS + 1;
  localparam int DERR_W   = SPEED_BITS + 2;
  localparam int PROD_W   = DERR_W + pidsl_pkg::GAIN_W;
  localparam int EXT_W    = (PROD_W > 63) ? PROD_W : 63;
  localparam int INT_W    = TERM_FRAC_BITS + 2;
  localparam int ISUM_W   = pidsl_pkg::TERM_W + 1;
  localparam int CMP_W    = (ERR_W > pidsl_pkg::MINSP_W) ? ERR_W : pidsl_pkg::MINSP_W;
  localparam int DIFF_W   = pidsl_pkg::FILT_W + 1;
  localparam int FPROD_W  = DIFF_W + pidsl_pkg::COEFF_W + 1;
  localparam int FSPLIT   = 24;
  localparam int FHI_W    = DIFF_W - FSPLIT + pidsl_pkg::COEFF_W + 1;
  localparam int FLO_W    = FSPLIT + pidsl_pkg::COEFF_W;
  localparam int SUM_W    = pidsl_pkg::TERM_W + 2;
  localparam int DEXT_W   = TERM_FRAC_BITS + 5;
  localparam int SHR      = (TERM_FRAC_BITS >= 15) ? TERM_FRAC_BITS - 15 : 0;
  localparam int SHL      = (TERM_FRAC_BITS < 15) ? 15 - TERM_FRAC_BITS : 0;
  localparam int ISHIFT   = 32 - TERM_FRAC_BITS;

  localparam logic [EXT_W-1:0] PROD_LIM = EXT_W'(1) << 62;
  localparam logic signed [ISUM_W-1:0] ONE_I = ISUM_W'(1) <<< TERM_FRAC_BITS;
  localparam logic signed [SUM_W-1:0]  ONE_S = SUM_W'(1) <<< TERM_FRAC_BITS;
  localparam logic signed [pidsl_pkg::TERM_W-1:0] D48_MAX =
    (pidsl_pkg::TERM_W'(1) <<< (pidsl_pkg::FILT_W - 1)) - pidsl_pkg::TERM_W'(1);
  localparam logic signed [pidsl_pkg::TERM_W-1:0] D48_MIN = -D48_MAX - pidsl_pkg::TERM_W'(1);

  // configuration
  logic [pidsl_pkg::GAIN_W-1:0]  p_gain;
  logic [pidsl_pkg::GAIN_W-1:0]  i_gain;
  logic [pidsl_pkg::GAIN_W-1:0]  d_gain;
  logic [pidsl_pkg::COEFF_W-1:0] d_coeff;
  logic [pidsl_pkg::MINSP_W-1:0] min_sp;

  // loop state
  logic signed [INT_W-1:0]                integral;
  logic signed [ERR_W-1:0]                last_error;
  logic signed [pidsl_pkg::FILT_W-1:0]    filt;
  logic signed [pidsl_pkg::DRIVE_W-1:0]   last_drive;

  // working registers
  logic signed [SPEED_BITS-1:0]           sp_q;
  logic signed [SPEED_BITS-1:0]           ms_q;
  logic signed [ERR_W-1:0]                err_q;
  logic signed [DERR_W-1:0]               derr_q;
  logic [PROD_W-1:0]                      prod_q;
  logic                                   neg_q;
  logic signed [pidsl_pkg::TERM_W-1:0]    p_q;
  logic signed [DIFF_W-1:0]               diff_q;
  logic signed [FPROD_W-1:0]              fprod_q;
  logic signed [pidsl_pkg::DRIVE_W-1:0]   drive_q;
  logic                                   idle_q;

  // combinational
  logic signed [ERR_W-1:0]                sp_ext;
  logic [ERR_W-1:0]                       asp;
  logic signed [ERR_W-1:0]                err_c;
  logic signed [DERR_W-1:0]               derr_c;
  logic signed [DERR_W-1:0]               mop;
  logic [pidsl_pkg::GAIN_W-1:0]           gain;
  logic [DERR_W-1:0]                      mag;
  logic [EXT_W-1:0]                       prod_ext;
  logic [62:0]                            mag_sat;
  logic signed [pidsl_pkg::TERM_W-1:0]    term;
  logic signed [pidsl_pkg::TERM_W-1:0]    inc;
  logic signed [ISUM_W-1:0]               isum;
  logic signed [ISUM_W-1:0]               iclamp;
  logic signed [pidsl_pkg::TERM_W-1:0]    dd;
  logic [pidsl_pkg::COEFF_W-1:0]          kc;
  logic signed [FHI_W-1:0]                fhi;
  logic [FLO_W-1:0]                       flo;
  logic signed [FPROD_W-1:0]              fstep;
  logic signed [FPROD_W-1:0]              fsum;
  logic signed [FPROD_W-1:0]              fclamp;
  logic signed [SUM_W-1:0]                ssum;
  logic signed [SUM_W-1:0]                sclamp;
  logic signed [DEXT_W-1:0]               sscaled;
  logic signed [pidsl_pkg::DRIVE_W-1:0]   drv_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_gain  <= '0;
      i_gain  <= '0;
      d_gain  <= '0;
      d_coeff <= pidsl_pkg::COEFF_ONE;
      min_sp  <= pidsl_pkg::MINSP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pidsl_pkg::CFG_P_GAIN:  p_gain  <= cfg_data;
        pidsl_pkg::CFG_I_GAIN:  i_gain  <= cfg_data;
        pidsl_pkg::CFG_D_GAIN:  d_gain  <= cfg_data;
        pidsl_pkg::CFG_D_COEFF: d_coeff <= cfg_data[pidsl_pkg::COEFF_W-1:0];
        pidsl_pkg::CFG_MIN_SP:  min_sp  <= cfg_data[pidsl_pkg::MINSP_W-1:0];
        default: ;
      endcase
    end
  end

  // error, derivative difference and idle test
  assign sp_ext = ERR_W'(sp_q);
  assign asp    = sp_ext[ERR_W-1] ? unsigned'(-sp_ext) : unsigned'(sp_ext);
  assign err_c  = ERR_W'(sp_q) - ERR_W'(ms_q);
  assign derr_c = DERR_W'(err_c) - DERR_W'(last_error);

  assign stat.idle_hit = CMP_W'(asp) < CMP_W'(min_sp);
  assign stat.out_free = !out_valid || out_ready;

  // shared gain multiplier on magnitudes
  always_comb begin
    case (ctl.mul_sel)
      pidsl_pkg::MUL_I: begin
        mop  = DERR_W'(err_q);
        gain = i_gain;
      end
      pidsl_pkg::MUL_D: begin
        mop  = derr_q;
        gain = d_gain;
      end
      default: begin
        mop  = DERR_W'(err_q);
        gain = p_gain;
      end
    endcase
  end

  assign mag = mop[DERR_W-1] ? unsigned'(-mop) : unsigned'(mop);

  // saturate at 2^62 and restore the sign
  assign prod_ext = EXT_W'(prod_q);
  assign mag_sat  = (prod_ext > PROD_LIM) ? PROD_LIM[62:0] : prod_ext[62:0];
  assign term     = neg_q ? -$signed({1'b0, mag_sat}) : $signed({1'b0, mag_sat});

  // integrator with clamp to +-one
  assign inc    = term >>> ISHIFT;
  assign isum   = ISUM_W'(integral) + ISUM_W'(inc);
  assign iclamp = (isum > ONE_I) ? ONE_I : ((isum < -ONE_I) ? -ONE_I : isum);

  // raw derivative clamped to 48 bits
  assign dd = (term > D48_MAX) ? D48_MAX : ((term < D48_MIN) ? D48_MIN : term);

  // low-pass filter step, difference times coefficient as high and low halves
  assign kc     = (d_coeff > pidsl_pkg::COEFF_ONE) ? pidsl_pkg::COEFF_ONE : d_coeff;
  assign fhi    = FHI_W'($signed(diff_q[DIFF_W-1:FSPLIT])) * FHI_W'($signed({1'b0, kc}));
  assign flo    = FLO_W'(diff_q[FSPLIT-1:0]) * FLO_W'(kc);
  assign fstep  = fprod_q >>> 16;
  assign fsum   = FPROD_W'(filt) + fstep;
  assign fclamp = (fsum > FPROD_W'(D48_MAX)) ? FPROD_W'(D48_MAX) :
                  ((fsum < FPROD_W'(D48_MIN)) ? FPROD_W'(D48_MIN) : fsum);

  // output sum, clamp and scale to q.15
  assign ssum    = SUM_W'(p_q) + SUM_W'(integral) + SUM_W'(filt);
  assign sclamp  = (ssum > ONE_S) ? ONE_S : ((ssum < -ONE_S) ? -ONE_S : ssum);
  assign sscaled = DEXT_W'(sclamp);
  assign drv_c   = pidsl_pkg::DRIVE_W'((sscaled >>> SHR) <<< SHL);

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      sp_q <= setpoint;
      ms_q <= measured;
    end
    if (ctl.err_ld) begin
      err_q  <= err_c;
      derr_q <= derr_c;
    end
    if (ctl.mul_en) begin
      prod_q <= PROD_W'(mag) * PROD_W'(gain);
      neg_q  <= mop[DERR_W-1];
    end
    if (ctl.take_p) begin
      p_q <= term;
    end
    if (ctl.take_d) begin
      diff_q <= DIFF_W'($signed(dd[pidsl_pkg::FILT_W-1:0])) - DIFF_W'(filt);
    end
    if (ctl.filt_mul) begin
      fprod_q <= (FPROD_W'(fhi) <<< FSPLIT) + $signed(FPROD_W'(flo));
    end
    if (ctl.idle_ld) begin
      drive_q <= last_drive;
      idle_q  <= 1'b1;
    end else if (ctl.sum_ld) begin
      drive_q <= drv_c;
      idle_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral   <= '0;
      last_error <= '0;
      filt       <= '0;
      last_drive <= '0;
    end else begin
      if (ctl.err_ld) begin
        last_error <= err_c;
      end
      if (ctl.idle_ld) begin
        integral <= '0;
      end else if (ctl.take_i) begin
        integral <= iclamp[INT_W-1:0];
      end
      if (ctl.filt_upd) begin
        filt <= fclamp[pidsl_pkg::FILT_W-1:0];
      end
      if (ctl.sum_ld) begin
        last_drive <= drv_c;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_push) begin
      drive <= drive_q;
      idle  <= idle_q;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/pid_speed_loop_filtered_derivative_top.sv
// top level of the speed loop pid controller with filtered derivative
//
// usage:
//   s_* carries one sample per beat: setpoint and measured speed, both signed.
//   m_* returns one beat per sample: the q.15 drive (-32768..32768) in m_tdata
//   and the idle flag in m_tuser, set when |setpoint| < min_setpoint and the
//   previous drive is repeated.
//   cfg_* writes one register per beat (index 0..4: p_gain, i_gain, d_gain,
//   d_filter_coeff, min_setpoint); unused indexes are dropped. cfg_ready is
//   always high; write only while no sample is in flight.
// sequence: one gain multiplier serves the p, i and d products in turn,
//   then come the filter multiply and the final sum. a sample goes from
//   the error state through those steps to done, which waits until the
//   output register is free; the idle path goes from error to done. a new
//   sample is taken only once the last one is handed to that register.
// reset: rst (synchronous, high) clears the integrator, filter, last error
//   and last drive, loads register defaults and drops m_tvalid.
// stall: a finished beat waits in the output register while the next sample
//   is taken and worked on; only the hand-off into that register waits.
`default_nettype none

module pid_speed_loop_filtered_derivative_top #(
  parameter int SPEED_BITS     = 18,
  parameter int TERM_FRAC_BITS = 24
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // sample input
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // [SPEED_BITS-1:0] setpoint, [2*SPEED_BITS-1:SPEED_BITS] measured, zero pad
  input  logic [((2*SPEED_BITS+7)/8)*8-1:0]       s_tdata,
  // drive output
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // [16:0] drive, zero pad
  output logic [pidsl_pkg::OUT_TDATA_W-1:0]       m_tdata,
  // [0] idle
  output logic                                    m_tuser,
  // register writes
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [pidsl_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [pidsl_pkg::CFG_DATA_W-1:0]        cfg_data
);

  pidsl_pkg::ctl_t  ctl;
  pidsl_pkg::stat_t stat;

  logic signed [SPEED_BITS-1:0]          setpoint;
  logic signed [SPEED_BITS-1:0]          measured;
  logic signed [pidsl_pkg::DRIVE_W-1:0]  drive;

  // unpack the input beat
  assign setpoint = $signed(s_tdata[SPEED_BITS-1:0]);
  assign measured = $signed(s_tdata[2*SPEED_BITS-1:SPEED_BITS]);

  assign s_tready  = ctl.in_ready;
  assign cfg_ready = 1'b1;

  pidsl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .stat     (stat),
    .ctl      (ctl)
  );

  pidsl_dp #(
    .SPEED_BITS     (SPEED_BITS),
    .TERM_FRAC_BITS (TERM_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .stat      (stat),
    .setpoint  (setpoint),
    .measured  (measured),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .drive     (drive),
    .idle      (m_tuser)
  );

  // pack the output beat
  assign m_tdata = {{(pidsl_pkg::OUT_TDATA_W - pidsl_pkg::DRIVE_W){1'b0}}, drive};

endmodule

`default_nettype wire

### hw/rtl/pidsl_chk.sv
// port-level checks for the speed loop pid controller, bound to the top level
`default_nettype none
`include "pid_speed_loop_filtered_derivative_top_defines.svh"

module pidsl_chk (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [pidsl_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input logic                                m_tuser
);

  // a stalled result beat holds
  `PIDSL_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output beat changed while stalled")

  // one sample at a time: ready drops after an accept
  `PIDSL_ASSERT(a_one_in_flight, s_tvalid && s_tready |=> !s_tready, "second sample taken while busy")

  // drive never exceeds +32768
  `PIDSL_ASSERT(a_drive_range, m_tvalid && !m_tdata[16] |-> !m_tdata[15] || m_tdata[14:0] == 15'd0, "drive above +1.0")

  // reset empties the output register
  `PIDSL_ASSERT_RST(a_reset_empty, rst |=> !m_tvalid, "output valid after reset")

endmodule

bind pid_speed_loop_filtered_derivative_top pidsl_chk u_pidsl_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
